>>> src/fm4_pkg.sv
// Shared types, constants, routing tables and sine table builder for the FM voice.
package fm4_pkg;

    localparam int OPERATOR_COUNT   = 4;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);
    localparam int PHASE_BITS       = 24;

    localparam int MUL_A_BITS = 35;
    localparam int MUL_B_BITS = 17;
    localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS + 1;

    typedef enum logic [3:0] {
        REG_ALGORITHM   = 4'd0,
        REG_STEP_OP0    = 4'd1,
        REG_STEP_OP1    = 4'd2,
        REG_STEP_OP2    = 4'd3,
        REG_STEP_OP3    = 4'd4,
        REG_OP_LEVELS   = 4'd5,
        REG_FB_AMOUNTS  = 4'd6,
        REG_VOICE_GAIN  = 4'd7
    } reg_index_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] src;
    } route_t;

    typedef struct packed {
        logic signed [MUL_A_BITS-1:0] a;
        logic [MUL_B_BITS-1:0]        b;
    } mul_req_t;

    localparam route_t RN = '{valid: 1'b0, src: 2'd0};
    localparam route_t R1 = '{valid: 1'b1, src: 2'd1};
    localparam route_t R2 = '{valid: 1'b1, src: 2'd2};
    localparam route_t R3 = '{valid: 1'b1, src: 2'd3};

    // [algorithm][operator][source slot]
    localparam route_t ROUTE_SRC [8][4][2] = '{
        '{'{R1, RN}, '{R2, RN}, '{R3, RN}, '{RN, RN}},
        '{'{R1, R3}, '{R2, RN}, '{RN, RN}, '{RN, RN}},
        '{'{R1, RN}, '{RN, RN}, '{R3, RN}, '{RN, RN}},
        '{'{RN, RN}, '{R2, RN}, '{R3, RN}, '{RN, RN}},
        '{'{R1, RN}, '{RN, RN}, '{RN, RN}, '{RN, RN}},
        '{'{RN, RN}, '{RN, RN}, '{R3, RN}, '{RN, RN}},
        '{'{RN, RN}, '{RN, RN}, '{RN, RN}, '{RN, RN}},
        '{'{RN, RN}, '{R3, RN}, '{R3, RN}, '{RN, RN}}
    };

    localparam logic [3:0] CARRIER_MASK [8] = '{
        4'h1, 4'h1, 4'h5, 4'h3, 4'hD, 4'h7, 4'hF, 4'h7
    };

    // 1/sqrt(carrier count) in Q1.16, per algorithm
    localparam logic [16:0] ALG_SCALE [8] = '{
        17'd65536, 17'd65536, 17'd46341, 17'd46341,
        17'd37837, 17'd37837, 17'd32768, 17'd37837
    };

    typedef logic signed [15:0] sine_tab_t [SINE_TABLE_DEPTH];

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [6] = '{
        64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
    };

    function automatic sine_tab_t build_sine();
        sine_tab_t   tab;
        logic [63:0] u, quad, r, x, x2, t, s, v;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            u    = (64'(k) << 32) / SINE_TABLE_DEPTH;
            quad = (u >> 30) & 64'd3;
            r    = u & (Q30_ONE - 64'd1);
            if (quad[0]) begin
                r = Q30_ONE - r;
            end
            x  = (r * HALF_PI_Q30) >> 30;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            for (int i = 0; i < 6; i++) begin
                t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_DIV[i];
            end
            s = (x * t) >> 30;
            v = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            tab[k] = (quad >= 64'd2) ? -$signed(v[15:0]) : $signed(v[15:0]);
        end
        return tab;
    endfunction

endpackage

>>> src/fm4_mul.sv
// Shared signed-by-unsigned multiplier with registered product.
module fm4_mul (
    input  logic                                 aclk,
    input  logic                                 en,
    input  fm4_pkg::mul_req_t                    req,
    output logic signed [fm4_pkg::MUL_P_BITS-1:0] prod
);
    import fm4_pkg::*;

    logic signed [MUL_P_BITS-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= MUL_P_BITS'(req.a * $signed({1'b0, req.b}));
        end
    end

    assign prod = prod_reg;

endmodule

>>> src/fm4_sine.sv
// Sine lookup table, signed Q1.15, registered read.
module fm4_sine (
    input  logic                               aclk,
    input  logic [fm4_pkg::SINE_ADDR_BITS-1:0] addr,
    output logic signed [15:0]                 q
);
    import fm4_pkg::*;

    localparam sine_tab_t SINE_TAB = build_sine();

    logic signed [15:0] q_reg;

    always_ff @(posedge aclk) begin
        q_reg <= SINE_TAB[addr];
    end

    assign q = q_reg;

endmodule

>>> src/four_operator_fm_voice_core.sv
// Four-operator FM voice: sequencer, operator state and configuration registers.
//
// A trigger item (tuser 1) clears operator phases and feedback memory and yields no
// sample. A tick item yields one sample: operators 3 down to 0 each sum their modulation
// sources and any nonzero feedback, then look up the sine; the carriers of the selected
// algorithm are then summed and scaled by the algorithm factor, the amplitude envelope and
// the voice gain. Every product goes through one shared registered multiplier, so operators,
// carriers and the final gain stages are processed one multiply at a time. The input is not
// ready while a tick is in progress; a finished sample waits in the final stage until the
// output register is free.
module four_operator_fm_voice_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // env_level_op0, env_level_op1, env_level_op2, env_level_op3, amp_env_level
    input  logic [79:0] s_tdata,
    // command
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // voice_sample
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import fm4_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SRC_A, S_SRC_B, S_SRC_C, S_FB_A, S_FB_C, S_LOOK, S_WRITE,
        S_CAR_A, S_CAR_B, S_CAR_C, S_SCALE, S_AMP, S_GAIN, S_FIN
    } state_t;

    state_t state_reg;

    logic [2:0]                  alg_reg;
    logic [PHASE_BITS-1:0]       step_reg [OPERATOR_COUNT];
    logic [63:0]                 levels_reg;
    logic [63:0]                 fb_reg;
    logic [15:0]                 gain_reg;

    logic [PHASE_BITS-1:0]       phase_reg [OPERATOR_COUNT];
    logic signed [15:0]          last_reg  [OPERATOR_COUNT];
    logic signed [15:0]          opout_reg [OPERATOR_COUNT];
    logic [15:0]                 env_reg   [OPERATOR_COUNT];
    logic [15:0]                 amp_reg;
    logic [1:0]                  op_reg;
    logic                        j_reg;
    logic [42:0]                 acc_reg;
    logic signed [49:0]          sum_reg;
    logic [15:0]                 m_data_reg;
    logic                        m_valid_reg;

    mul_req_t                    mreq;
    logic                        mul_en;
    logic signed [MUL_P_BITS-1:0] mul_p;
    logic [SINE_ADDR_BITS-1:0]   sine_addr;
    logic signed [15:0]          sine_q;

    route_t                      rt;
    logic [PHASE_BITS-1:0]       phase_mod;
    logic signed [23:0]          fin_val;
    logic [15:0]                 fin_sat;
    logic                        in_acc;
    logic                        out_free;

    fm4_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .req  (mreq),
        .prod (mul_p)
    );

    fm4_sine u_sine (
        .aclk (aclk),
        .addr (sine_addr),
        .q    (sine_q)
    );

    function automatic logic [15:0] field16(input logic [63:0] packed_v, input logic [1:0] i);
        return packed_v[{i, 4'b0000} +: 16];
    endfunction

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    // final product is held while the sample waits
    assign mul_en    = (state_reg != S_FIN);

    assign rt        = ROUTE_SRC[alg_reg][op_reg][j_reg];
    assign phase_mod = phase_reg[op_reg] + acc_reg[42 -: PHASE_BITS];
    assign sine_addr = phase_mod[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign fin_val   = mul_p[52:29];

    always_comb begin
        if (fin_val > 24'sd32767) begin
            fin_sat = 16'h7FFF;
        end else if (fin_val < -24'sd32768) begin
            fin_sat = 16'h8000;
        end else begin
            fin_sat = fin_val[15:0];
        end
    end

    always_comb begin
        mreq.a = '0;
        mreq.b = '0;
        case (state_reg)
            S_SRC_A: begin
                mreq.a = MUL_A_BITS'(opout_reg[rt.src]);
                mreq.b = {1'b0, field16(levels_reg, rt.src)};
            end
            S_SRC_B: begin
                mreq.a = $signed(mul_p[MUL_A_BITS-1:0]);
                mreq.b = {1'b0, env_reg[rt.src]};
            end
            S_FB_A: begin
                mreq.a = MUL_A_BITS'(last_reg[op_reg]);
                mreq.b = {1'b0, field16(fb_reg, op_reg)};
            end
            S_CAR_A: begin
                mreq.a = MUL_A_BITS'(opout_reg[op_reg]);
                mreq.b = {1'b0, field16(levels_reg, op_reg)};
            end
            S_CAR_B: begin
                mreq.a = $signed(mul_p[MUL_A_BITS-1:0]);
                mreq.b = {1'b0, env_reg[op_reg]};
            end
            S_SCALE: begin
                mreq.a = MUL_A_BITS'($signed(sum_reg[49:16]));
                mreq.b = ALG_SCALE[alg_reg];
            end
            S_AMP: begin
                mreq.a = MUL_A_BITS'($signed(mul_p[49:16]));
                mreq.b = {1'b0, amp_reg};
            end
            S_GAIN: begin
                mreq.a = MUL_A_BITS'($signed(mul_p[49:16]));
                mreq.b = {1'b0, gain_reg};
            end
            default: begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alg_reg    <= '0;
            levels_reg <= '0;
            fb_reg     <= '0;
            gain_reg   <= '0;
            for (int i = 0; i < OPERATOR_COUNT; i++) begin
                step_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ALGORITHM:  alg_reg     <= cfg_data[2:0];
                REG_STEP_OP0:   step_reg[0] <= cfg_data[PHASE_BITS-1:0];
                REG_STEP_OP1:   step_reg[1] <= cfg_data[PHASE_BITS-1:0];
                REG_STEP_OP2:   step_reg[2] <= cfg_data[PHASE_BITS-1:0];
                REG_STEP_OP3:   step_reg[3] <= cfg_data[PHASE_BITS-1:0];
                REG_OP_LEVELS:  levels_reg  <= cfg_data;
                REG_FB_AMOUNTS: fb_reg      <= cfg_data;
                REG_VOICE_GAIN: gain_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            op_reg      <= '0;
            j_reg       <= 1'b0;
            for (int i = 0; i < OPERATOR_COUNT; i++) begin
                phase_reg[i] <= '0;
                last_reg[i]  <= '0;
            end
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        if (s_tuser[0]) begin
                            for (int i = 0; i < OPERATOR_COUNT; i++) begin
                                phase_reg[i] <= '0;
                                last_reg[i]  <= '0;
                            end
                        end else begin
                            for (int i = 0; i < OPERATOR_COUNT; i++) begin
                                env_reg[i] <= s_tdata[16*i +: 16];
                            end
                            amp_reg   <= s_tdata[79:64];
                            op_reg    <= 2'd3;
                            j_reg     <= 1'b0;
                            acc_reg   <= '0;
                            state_reg <= S_SRC_A;
                        end
                    end
                end
                S_SRC_A: begin
                    state_reg <= rt.valid ? S_SRC_B : S_FB_A;
                end
                S_SRC_B: begin
                    state_reg <= S_SRC_C;
                end
                S_SRC_C: begin
                    acc_reg <= acc_reg + mul_p[42:0];
                    if (!j_reg) begin
                        j_reg     <= 1'b1;
                        state_reg <= S_SRC_A;
                    end else begin
                        state_reg <= S_FB_A;
                    end
                end
                S_FB_A: begin
                    state_reg <= (field16(fb_reg, op_reg) != 16'd0) ? S_FB_C : S_LOOK;
                end
                S_FB_C: begin
                    acc_reg   <= acc_reg + {mul_p[26:0], 16'b0};
                    state_reg <= S_LOOK;
                end
                S_LOOK: begin
                    phase_reg[op_reg] <= phase_reg[op_reg] + step_reg[op_reg];
                    state_reg         <= S_WRITE;
                end
                S_WRITE: begin
                    opout_reg[op_reg] <= sine_q;
                    last_reg[op_reg]  <= sine_q;
                    if (op_reg == 2'd0) begin
                        sum_reg   <= '0;
                        state_reg <= S_CAR_A;
                    end else begin
                        op_reg    <= op_reg - 2'd1;
                        j_reg     <= 1'b0;
                        acc_reg   <= '0;
                        state_reg <= S_SRC_A;
                    end
                end
                S_CAR_A: begin
                    if (CARRIER_MASK[alg_reg][op_reg]) begin
                        state_reg <= S_CAR_B;
                    end else if (op_reg == 2'd3) begin
                        state_reg <= S_SCALE;
                    end else begin
                        op_reg <= op_reg + 2'd1;
                    end
                end
                S_CAR_B: begin
                    state_reg <= S_CAR_C;
                end
                S_CAR_C: begin
                    sum_reg <= sum_reg + mul_p[49:0];
                    if (op_reg == 2'd3) begin
                        state_reg <= S_SCALE;
                    end else begin
                        op_reg    <= op_reg + 2'd1;
                        state_reg <= S_CAR_A;
                    end
                end
                S_SCALE: state_reg <= S_AMP;
                S_AMP:   state_reg <= S_GAIN;
                S_GAIN:  state_reg <= S_FIN;
                S_FIN: begin
                    if (out_free) begin
                        m_data_reg  <= fin_sat;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_trigger_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && s_tuser[0] |=> phase_reg[0] == '0 && phase_reg[3] == '0 &&
            last_reg[0] == '0 && last_reg[3] == '0)
        else $error("trigger did not clear operator state");

    a_tick_starts_op3: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && !s_tuser[0] |=> state_reg == S_SRC_A && op_reg == 2'd3 && acc_reg == '0)
        else $error("tick did not start at operator 3");

    a_to_carriers: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WRITE && op_reg == 2'd0 |=> state_reg == S_CAR_A && op_reg == 2'd0)
        else $error("carrier pass did not follow operator 0");

    a_out_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("sample presented outside final stage");

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the four-operator FM voice core with a bit-exact predictor.
`timescale 1ns / 1ps

module tb_top;
    import fm4_pkg::*;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          SETTLE_CYCLES  = 64;
    localparam logic [3:0]  REG_INDEX_LIMIT = 4'd8;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] HALF_PI = 64'd1686629713;
    localparam logic        CMD_TICK    = 1'b0;
    localparam logic        CMD_TRIGGER = 1'b1;

    typedef struct {
        logic        cmd;
        logic [79:0] env;
    } voice_item_t;

    // [algorithm][operator][slot], -1 marks an unused slot
    localparam int MOD_SRC [8][4][2] = '{
        '{'{1, -1}, '{2, -1}, '{3, -1}, '{-1, -1}},
        '{'{1, 3}, '{2, -1}, '{-1, -1}, '{-1, -1}},
        '{'{1, -1}, '{-1, -1}, '{3, -1}, '{-1, -1}},
        '{'{-1, -1}, '{2, -1}, '{3, -1}, '{-1, -1}},
        '{'{1, -1}, '{-1, -1}, '{-1, -1}, '{-1, -1}},
        '{'{-1, -1}, '{-1, -1}, '{3, -1}, '{-1, -1}},
        '{'{-1, -1}, '{-1, -1}, '{-1, -1}, '{-1, -1}},
        '{'{-1, -1}, '{3, -1}, '{3, -1}, '{-1, -1}}
    };
    localparam logic [3:0]  CARRIERS [8] = '{4'h1, 4'h1, 4'h5, 4'h3, 4'hD, 4'h7, 4'hF, 4'h7};
    localparam longint      NORM_Q16 [5] = '{65536, 65536, 46341, 37837, 32768};
    localparam logic [63:0] SERIES_DIV [6] = '{156, 110, 72, 42, 20, 6};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    always #10 aclk = ~aclk;

    four_operator_fm_voice_core uut (.*);

    logic signed [15:0] sine_lut [1024];
    logic [2:0]         alg_reg;
    logic [23:0]        step_reg [4];
    logic [63:0]        levels_reg, fb_reg;
    logic [15:0]        gain_reg;
    logic [23:0]        phase_acc [4];
    logic signed [15:0] prev_out [4];

    voice_item_t        pending_items [$];
    logic signed [15:0] expected_samples [$];
    int                 mismatches = 0;
    int                 samples_seen = 0, triggers_sent = 0, cfg_writes = 0;
    int                 idle_cycles = 0;
    logic               s_fire = 1'b0, cfg_fire = 1'b0;
    int                 burst_left = 0, gap_left = 0;
    int                 rx_mode = 0, rx_count = 0;

    function automatic void build_sine_lut();
        logic [63:0] u, quad, r, x, x2, t, s, v;
        for (int k = 0; k < 1024; k++) begin
            u    = 64'(k) << 22;
            quad = (u >> 30) & 64'd3;
            r    = u & (ONE_Q30 - 64'd1);
            if (quad[0]) begin
                r = ONE_Q30 - r;
            end
            x  = (r * HALF_PI) >> 30;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            for (int i = 0; i < 6; i++) begin
                t = ONE_Q30 - ((x2 * t) >> 30) / SERIES_DIV[i];
            end
            s = (x * t) >> 30;
            v = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            sine_lut[k] = (quad >= 64'd2) ? -16'(v) : 16'(v);
        end
    endfunction

    function automatic longint lane16(logic [63:0] packed_val, int op);
        return longint'(packed_val[16*op +: 16]);
    endfunction

    function automatic bit render_sample(voice_item_t it, output logic signed [15:0] res);
        longint      op_val [4];
        longint      envs [4];
        longint      mod, acc, smp;
        logic [23:0] p;
        int          src, n;
        res = '0;
        if (it.cmd == CMD_TRIGGER) begin
            for (int op = 0; op < 4; op++) begin
                phase_acc[op] = '0;
                prev_out[op]  = '0;
            end
            return 1'b0;
        end
        for (int op = 0; op < 4; op++) begin
            envs[op]   = longint'(it.env[16*op +: 16]);
            op_val[op] = 0;
        end
        for (int op = 3; op >= 0; op--) begin
            mod = 0;
            for (int j = 0; j < 2; j++) begin
                src = MOD_SRC[alg_reg][op][j];
                if (src < 0) break;
                mod += op_val[src] * lane16(levels_reg, src) * envs[src];
            end
            if (lane16(fb_reg, op) > 0) begin
                mod += longint'(prev_out[op]) * lane16(fb_reg, op) * 65536;
            end
            p = phase_acc[op] + 24'(mod >>> 19);
            op_val[op]    = longint'(sine_lut[p[23:14]]);
            prev_out[op]  = 16'(op_val[op]);
            phase_acc[op] = phase_acc[op] + step_reg[op];
        end
        acc = 0;
        n   = 0;
        for (int op = 0; op < 4; op++) begin
            if (CARRIERS[alg_reg][op]) begin
                acc += op_val[op] * lane16(levels_reg, op) * envs[op];
                n++;
            end
        end
        smp = acc >>> 16;
        smp = (smp * NORM_Q16[n]) >>> 16;
        smp = (smp * longint'(it.env[79:64])) >>> 16;
        smp = (smp * longint'(gain_reg)) >>> 16;
        smp = smp >>> 13;
        if (smp > 32767) smp = 32767;
        if (smp < -32768) smp = -32768;
        res = 16'(smp);
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t: %s voice_sample got %0d want %0d", $realtime, what,
                 $signed(got), $signed(want));
        mismatches++;
    endtask

    // input, config and result monitors; predictor runs on each accepted item
    always @(posedge aclk) begin
        logic signed [15:0] res;
        logic signed [15:0] want;
        voice_item_t        it;
        s_fire   <= s_tvalid && s_tready;
        cfg_fire <= cfg_valid && cfg_ready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                it.cmd = s_tuser[0];
                it.env = s_tdata;
                if (render_sample(it, res)) begin
                    expected_samples.push_back(res);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ALGORITHM:  alg_reg     = cfg_data[2:0];
                    REG_STEP_OP0:   step_reg[0] = cfg_data[23:0];
                    REG_STEP_OP1:   step_reg[1] = cfg_data[23:0];
                    REG_STEP_OP2:   step_reg[2] = cfg_data[23:0];
                    REG_STEP_OP3:   step_reg[3] = cfg_data[23:0];
                    REG_OP_LEVELS:  levels_reg  = cfg_data;
                    REG_FB_AMOUNTS: fb_reg      = cfg_data;
                    REG_VOICE_GAIN: gain_reg    = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                samples_seen++;
                if (expected_samples.size() == 0) begin
                    report_mismatch("unexpected", m_tdata, 16'h0);
                end else begin
                    want = expected_samples.pop_front();
                    if (m_tdata !== want) report_mismatch("wrong", m_tdata, want);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // sender: bursts of items with random gaps
    always @(negedge aclk) begin
        voice_item_t it;
        if (aresetn && (!s_tvalid || s_fire)) begin
            if (gap_left > 0 || pending_items.size() == 0) begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                it = pending_items.pop_front();
                s_tdata  <= it.env;
                s_tuser  <= it.cmd;
                s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // receiver: stall pattern is reselected at random from four modes
    always @(negedge aclk) begin
        rx_count++;
        if (rx_count[5:0] == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            2:       m_tready <= (rx_count[3:0] > 4'd11);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic write_reg(logic [3:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_fire);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || expected_samples.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic queue_item(logic cmd, logic [79:0] env);
        voice_item_t it;
        it.cmd = cmd;
        it.env = env;
        if (cmd == CMD_TRIGGER) triggers_sent++;
        pending_items.push_back(it);
    endtask

    function automatic logic [15:0] rand_env();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_lanes(bit allow_zero);
        logic [63:0] v;
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 5))
                0:       v[16*i +: 16] = allow_zero ? 16'h0 : 16'($urandom);
                1:       v[16*i +: 16] = 16'hFFFF;
                2:       v[16*i +: 16] = 16'($urandom_range(0, 16'h1FFF));
                default: v[16*i +: 16] = 16'($urandom);
            endcase
        end
        return v;
    endfunction

    function automatic logic [23:0] rand_step();
        case ($urandom_range(0, 5))
            0:       return 24'h0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom_range(0, 24'h3FFFF));
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        logic [63:0] env_word;
        build_sine_lut();
        alg_reg    = '0;
        levels_reg = '0;
        fb_reg     = '0;
        gain_reg   = '0;
        for (int op = 0; op < 4; op++) begin
            step_reg[op]  = '0;
            phase_acc[op] = '0;
            prev_out[op]  = '0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // ticks with every register at reset, then extremes on all registers
        queue_item(CMD_TICK, {80{1'b1}});
        wait_idle();
        write_reg(REG_STEP_OP0, 64'hFFFFFF);
        write_reg(REG_STEP_OP1, 64'h000001);
        write_reg(REG_STEP_OP2, 64'h800000);
        write_reg(REG_STEP_OP3, 64'hFFFFFF);
        write_reg(REG_OP_LEVELS, {64{1'b1}});
        write_reg(REG_FB_AMOUNTS, {64{1'b1}});
        write_reg(REG_VOICE_GAIN, 64'hFFFF);
        // writes above the register map must be ignored
        for (int k = 0; k < 8; k++) write_reg(REG_INDEX_LIMIT + 4'(k), {64{1'b1}});
        for (int a = 0; a < 8; a++) begin
            write_reg(REG_ALGORITHM, 64'(a));
            queue_item(CMD_TICK, {80{1'b1}});
            queue_item(CMD_TICK, (a % 2) ? 80'h0 : {16'hFFFF, 64'h0});
            queue_item(CMD_TRIGGER, (a % 2) ? {80{1'b1}} : 80'h0);
            wait_idle();
        end

        for (int ph = 0; ph < 14; ph++) begin
            write_reg(REG_ALGORITHM, 64'($urandom_range(0, 7)));
            write_reg(REG_STEP_OP0, 64'(rand_step()));
            write_reg(REG_STEP_OP1, 64'(rand_step()));
            write_reg(REG_STEP_OP2, 64'(rand_step()));
            write_reg(REG_STEP_OP3, 64'(rand_step()));
            write_reg(REG_OP_LEVELS, (ph == 3) ? {64{1'b1}} : rand_lanes(1'b0));
            write_reg(REG_FB_AMOUNTS, (ph == 5) ? 64'h0 : rand_lanes(1'b1));
            write_reg(REG_VOICE_GAIN, (ph % 4 == 0) ? 64'hFFFF : 64'($urandom));
            if ($urandom_range(0, 1)) write_reg(REG_INDEX_LIMIT + 4'($urandom_range(0, 7)),
                                                {$urandom, $urandom});
            for (int i = 0; i < 100; i++) begin
                env_word = {rand_env(), rand_env(), rand_env(), rand_env()};
                if ($urandom_range(0, 29) == 0)
                    queue_item(CMD_TRIGGER, {16'($urandom), env_word});
                else
                    queue_item(CMD_TICK, {rand_env(), env_word});
            end
            wait_idle();
        end

        $display("Run covered %0d samples, %0d note triggers and %0d register writes.",
                 samples_seen, triggers_sent, cfg_writes);
        $display("All eight routings, register extremes and ignored indexes exercised.");
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
src/fm4_pkg.sv
src/fm4_mul.sv
src/fm4_sine.sv
src/four_operator_fm_voice_core.sv
bench/tb_top.sv
